// ===== src/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Item layouts for the request and response channels, field widths and
// the reset value of the overlap threshold register.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int INDEX_W = 12;
   localparam int TOTAL_W = 7;
   localparam int THR_W   = 16;

   // IoU threshold after reset, Q0.16 (about 0.45)
   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // default sizing
   localparam int MAX_KEPT_DEFAULT       = 64;
   localparam int MAX_CANDIDATES_DEFAULT = 4096;

   // highest value the candidate index may reach
   localparam int INDEX_CAP = (1 << INDEX_W) - 1;

   // one box as stored in the kept table
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
   } box_type;

   // request item
   typedef struct packed {
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_top;
      logic [COORD_W-1:0] box_right;
      logic [COORD_W-1:0] box_bottom;
      logic               frame_end;
   } req_item_type;

   // response item
   typedef struct packed {
      logic               kept;
      logic               overflow;
      logic [INDEX_W-1:0] candidate_index;
      logic [TOTAL_W-1:0] kept_total;
      logic               result_last;
   } rsp_item_type;

   // extent of an interval, zero when inverted or empty
   function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                               input logic [COORD_W-1:0] hi);
      logic [COORD_W-1:0] result;
      result = (hi > lo) ? (hi - lo) : '0;
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== src/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression: class-agnostic greedy non-maximum suppression
//
// Candidate boxes arrive on the req_ channel in descending score order, one
// item per box. Each candidate is checked against every box kept so far in
// the frame; it is dropped when inter * 65536 > overlap_threshold * union
// for any kept box (a zero union never drops). Survivors are stored in a
// table of MAX_KEPT entries; once it is full they are flagged as overflow.
// Every candidate yields exactly one rsp_ item. frame_end closes the frame:
// the table and the candidate index are cleared after its response.
//
// Sequencing: one candidate at a time. With K > 0 boxes kept, the K kept
// boxes are read in turn in the scan state and fed through the compare
// pipeline, which then drains before the write-back cycle stores a survivor
// and registers the response; with an empty table the scan is skipped. The
// next candidate can be accepted in the cycle after the write-back. The
// response sits in an output register; the next candidate is accepted
// while it waits, and work stalls in the write-back cycle only while it is
// still not taken. Reset empties the table and the index, and sets the
// threshold to 29491; csr_ writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression
   import gbs_pkg::*;
#(
   parameter int MAX_KEPT       = MAX_KEPT_DEFAULT,
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // candidate items
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_data,
   // result items
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data,
   // threshold register
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [THR_W-1:0] csr_data
);

   localparam int CNT_W     = $clog2(MAX_KEPT + 1);
   localparam int ADDR_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int IDX_LIMIT = (MAX_CANDIDATES - 1 > INDEX_CAP) ? INDEX_CAP
                                                               : MAX_CANDIDATES - 1;
   localparam int AREA_W    = 2 * COORD_W;
   localparam int UNION_W   = AREA_W + 1;
   localparam int PROD_W    = THR_W + UNION_W;

   localparam logic [CNT_W-1:0]   KEPT_FULL = CNT_W'(MAX_KEPT);
   localparam logic [INDEX_W-1:0] IDX_TOP   = INDEX_W'(IDX_LIMIT);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   kept_count_ff, kept_count_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               suppress_ff, suppress_in;
   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;

   // candidate payload
   box_type            cand_ff, cand_in;
   logic               last_ff, last_in;
   logic [AREA_W-1:0]  area_c_ff, area_c_in;
   rsp_item_type       rsp_ff, rsp_in;

   // compare pipeline payload
   box_type            rd_box_ff;
   logic [AREA_W-1:0]  inter2_ff, inter2_in;
   logic [AREA_W-1:0]  area_k2_ff, area_k2_in;
   logic [AREA_W-1:0]  inter3_ff;
   logic [UNION_W-1:0] union3_ff, union3_in;
   logic [AREA_W-1:0]  inter4_ff;
   logic               union_nz4_ff;
   logic [PROD_W-1:0]  prod4_ff, prod4_in;

   // kept table
   box_type            kept_mem [MAX_KEPT];

   logic               req_fire;
   logic               out_free;
   logic               finish_go;
   logic               keep;
   logic               store;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CNT_W-1:0]   count_after;
   logic [CNT_W+TOTAL_W-1:0] total_ext;
   logic [COORD_W-1:0] ov_x0, ov_x1, ov_y0, ov_y1;
   logic               hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == ST_FINISH) && out_free;
   assign keep      = !suppress_ff;
   assign store     = keep && (kept_count_ff < KEPT_FULL);
   assign rd_addr   = scan_ff[ADDR_W-1:0];
   assign wr_addr   = kept_count_ff[ADDR_W-1:0];
   assign count_after = store ? kept_count_ff + 1'b1 : kept_count_ff;
   assign total_ext = {{TOTAL_W{1'b0}}, count_after};

   // candidate capture, area of the candidate
   always_comb begin
      cand_in   = cand_ff;
      last_in   = last_ff;
      area_c_in = area_c_ff;
      if (req_fire) begin
         cand_in.left   = req_data.box_left;
         cand_in.top    = req_data.box_top;
         cand_in.right  = req_data.box_right;
         cand_in.bottom = req_data.box_bottom;
         last_in        = req_data.frame_end;
         area_c_in      = AREA_W'(span(req_data.box_left, req_data.box_right))
                        * AREA_W'(span(req_data.box_top, req_data.box_bottom));
      end
   end

   // stage 2: overlap rectangle and kept box area
   always_comb begin
      ov_x0 = (cand_ff.left > rd_box_ff.left) ? cand_ff.left : rd_box_ff.left;
      ov_x1 = (cand_ff.right < rd_box_ff.right) ? cand_ff.right : rd_box_ff.right;
      ov_y0 = (cand_ff.top > rd_box_ff.top) ? cand_ff.top : rd_box_ff.top;
      ov_y1 = (cand_ff.bottom < rd_box_ff.bottom) ? cand_ff.bottom : rd_box_ff.bottom;
      inter2_in  = AREA_W'(span(ov_x0, ov_x1)) * AREA_W'(span(ov_y0, ov_y1));
      area_k2_in = AREA_W'(span(rd_box_ff.left, rd_box_ff.right))
                 * AREA_W'(span(rd_box_ff.top, rd_box_ff.bottom));
   end

   // stage 3: union; stage 4: threshold times union
   assign union3_in = UNION_W'(area_c_ff) + UNION_W'(area_k2_ff) - UNION_W'(inter2_ff);
   assign prod4_in  = PROD_W'(threshold_ff) * PROD_W'(union3_ff);

   // stage 5: suppression test
   assign hit = union_nz4_ff
             && ({1'b0, inter4_ff, {COORD_W{1'b0}}} > prod4_ff);

   // sequencer and frame bookkeeping
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      suppress_in   = suppress_ff;
      kept_count_in = kept_count_ff;
      index_in      = index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      threshold_in  = csr_valid ? csr_data : threshold_ff;

      if (v4_ff && hit) begin
         suppress_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scan_in     = '0;
               suppress_in = 1'b0;
               state_in    = (kept_count_ff == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff + 1'b1 == kept_count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !v4_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.kept              = store;
               rsp_in.overflow          = keep && !store;
               rsp_in.candidate_index   = index_ff;
               rsp_in.kept_total        = total_ext[TOTAL_W-1:0];
               rsp_in.result_last       = last_ff;
               kept_count_in            = last_ff ? '0 : count_after;
               if (last_ff) begin
                  index_in = '0;
               end else if (index_ff < IDX_TOP) begin
                  index_in = index_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         suppress_ff   <= 1'b0;
         kept_count_ff <= '0;
         index_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         threshold_ff  <= THR_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         suppress_ff   <= suppress_in;
         kept_count_ff <= kept_count_in;
         index_ff      <= index_in;
         rsp_valid_ff  <= rsp_valid_in;
         threshold_ff  <= threshold_in;
         v1_ff         <= (state_ff == ST_SCAN);
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
      end
   end

   // payload and pipeline registers
   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      last_ff      <= last_in;
      area_c_ff    <= area_c_in;
      rsp_ff       <= rsp_in;
      inter2_ff    <= inter2_in;
      area_k2_ff   <= area_k2_in;
      inter3_ff    <= inter2_ff;
      union3_ff    <= union3_in;
      inter4_ff    <= inter3_ff;
      union_nz4_ff <= (union3_ff != '0);
      prod4_ff     <= prod4_in;
   end

   // kept table: one read per scan cycle, write-back of a survivor
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) begin
         rd_box_ff <= kept_mem[rd_addr];
      end
      if (finish_go && store) begin
         kept_mem[wr_addr] <= cand_ff;
      end
   end

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= KEPT_FULL)
      else $error("kept count beyond table size");

   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_TOP)
      else $error("candidate index beyond its limit");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.kept && rsp_ff.overflow))
      else $error("response both kept and overflow");

   a_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !(v1_ff || v2_ff || v3_ff || v4_ff))
      else $error("write-back with compares still in flight");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      finish_go && keep && !store |-> kept_count_ff == KEPT_FULL)
      else $error("overflow reported with room in the table");

endmodule

`default_nettype wire
